### rtl/burst_fire_motion_sequencer_core_defines.svh
// Assertion macros for the feed sequencer checker
`ifndef BURST_FIRE_MOTION_SEQUENCER_CORE_DEFINES_SVH
`define BURST_FIRE_MOTION_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define BFMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bfms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfms_pkg;

    localparam int POSITION_BITS_DEF = 24;
    localparam int TIME_BITS_DEF     = 32;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_POS_A     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POS_B     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BURST     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPINUP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOL       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRE_POW  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_POW  = 3'd7;

    localparam logic [10:0] FLY_RUN  = 11'd1300;
    localparam logic [10:0] FLY_STOP = 11'd540;

    localparam int          POS_A_RST    = 0;
    localparam int          POS_B_RST    = -600;
    localparam logic [7:0]  BURST_RST    = 8'd5;
    localparam logic [15:0] SPINUP_RST   = 16'd600;
    localparam logic [15:0] TIMEOUT_RST  = 16'd300;
    localparam logic [9:0]  TOL_RST      = 10'd10;
    localparam logic [6:0]  FIRE_POW_RST = 7'd127;
    localparam logic [6:0]  HOLD_POW_RST = 7'd32;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SPINUP = 3'd1,
        PH_TO_A   = 3'd2,
        PH_TO_B   = 3'd3,
        PH_RETURN = 3'd4
    } t_phase;

    typedef struct packed {
        logic go_spin;
        logic go_fire;
        logic go_b;
        logic shot;
        logic shot_blk;
        logic go_idle;
    } t_steps;

endpackage

`default_nettype wire

### rtl/burst_fire_motion_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// in        sink       i_in_valid / o_in_stall      now_ms, trigger_level, motor_position
// out       source     o_out_valid / i_out_stall    motor_target, drive_power,
//                                                   flywheel_compare, phase
// cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One poll per cycle sustained while the result side is not stalled; an input beat passes
// the input register, then the phase cascade into the state/result register.
// All phase transitions of one poll resolve in a single combinational pass.
// Synchronous active-low reset clears control and loads register defaults.
// A stalled result holds the state; the input register takes one more beat, then stalls.

module burst_fire_motion_sequencer_core #(
    parameter int POSITION_BITS = bfms_pkg::POSITION_BITS_DEF,
    parameter int TIME_BITS     = bfms_pkg::TIME_BITS_DEF,
    localparam int CFG_BITS     = (POSITION_BITS > 16) ? POSITION_BITS : 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [TIME_BITS-1:0]                i_now_ms,
    input  wire logic                                i_trigger_level,
    input  wire logic signed [POSITION_BITS-1:0]     i_motor_position,

    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [POSITION_BITS-1:0]          o_motor_target,
    output logic [6:0]                               o_drive_power,
    output logic [10:0]                              o_flywheel_compare,
    output logic [2:0]                               o_phase,

    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bfms_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [CFG_BITS-1:0]                 i_cfg_data
);

    import bfms_pkg::*;

    logic signed [POSITION_BITS-1:0] r_cfg_pos_a;
    logic signed [POSITION_BITS-1:0] r_cfg_pos_b;
    logic [7:0]                      r_cfg_burst;
    logic [15:0]                     r_cfg_spinup;
    logic [15:0]                     r_cfg_timeout;
    logic [9:0]                      r_cfg_tol;
    logic [6:0]                      r_cfg_fire_pow;
    logic [6:0]                      r_cfg_hold_pow;

    logic                            r_s1_valid;
    logic [TIME_BITS-1:0]            r_s1_now;
    logic                            r_s1_trig;
    logic signed [POSITION_BITS-1:0] r_s1_pos;

    logic                            r_out_valid;
    t_phase                          r_phase;
    logic [TIME_BITS-1:0]            r_start;
    logic [7:0]                      r_shots;
    logic                            r_last_trig;
    logic signed [POSITION_BITS-1:0] r_target;
    logic [6:0]                      r_power;
    logic [10:0]                     r_fly;

    t_phase                          n_phase;
    logic [TIME_BITS-1:0]            n_start;
    logic [7:0]                      n_shots;
    logic signed [POSITION_BITS-1:0] n_target;
    logic [6:0]                      n_power;
    logic [10:0]                     n_fly;

    logic                            s2_free;
    logic                            take;
    t_steps                          steps;
    logic                            trig_fall;
    logic [TIME_BITS-1:0]            elapsed;
    logic                            el_ge_spin;
    logic                            el_ge_to;
    logic                            spin_zero;
    logic                            to_zero;
    logic                            arr_a;
    logic                            arr_b;
    logic [7:0]                      shots_cur;
    logic [7:0]                      shots_dec;

    function automatic logic near(
        input logic signed [POSITION_BITS-1:0] pos,
        input logic signed [POSITION_BITS-1:0] tgt,
        input logic [9:0]                      tol
    );
        logic signed [POSITION_BITS:0] d;
        logic [POSITION_BITS:0]        ad;
        d  = {pos[POSITION_BITS-1], pos} - {tgt[POSITION_BITS-1], tgt};
        ad = d[POSITION_BITS] ? (~d + 1'b1) : d;
        return ad < (POSITION_BITS+1)'(tol);
    endfunction

    assign s2_free     = !r_out_valid || !i_out_stall;
    assign take        = r_s1_valid && s2_free;
    assign o_in_stall  = r_s1_valid && !s2_free;
    assign o_cfg_ready = 1'b1;

    assign trig_fall  = r_last_trig && !r_s1_trig && r_phase == PH_IDLE;
    assign elapsed    = r_s1_now - r_start;
    assign el_ge_spin = elapsed >= TIME_BITS'(r_cfg_spinup);
    assign el_ge_to   = elapsed >= TIME_BITS'(r_cfg_timeout);
    assign spin_zero  = r_cfg_spinup == 16'd0;
    assign to_zero    = r_cfg_timeout == 16'd0;
    assign arr_a      = near(r_s1_pos, r_cfg_pos_a, r_cfg_tol);
    assign arr_b      = near(r_s1_pos, r_cfg_pos_b, r_cfg_tol);
    assign shots_cur  = trig_fall ? ((r_cfg_burst == 8'd0) ? 8'd1 : r_cfg_burst) : r_shots;
    assign shots_dec  = shots_cur - 8'd1;

    // phase cascade
    always_comb begin
        t_phase ph;
        logic   moved;
        logic   blk;
        ph    = r_phase;
        moved = 1'b0;
        blk   = 1'b0;
        steps = '0;
        if (trig_fall) begin
            steps.go_spin = 1'b1;
            ph    = PH_SPINUP;
            moved = 1'b1;
        end
        if (ph == PH_SPINUP && (moved ? spin_zero : el_ge_spin)) begin
            steps.go_fire = 1'b1;
            ph    = PH_TO_A;
            moved = 1'b1;
        end
        if (ph == PH_TO_A && (arr_a || (moved ? to_zero : el_ge_to))) begin
            steps.go_b = 1'b1;
            ph    = PH_TO_B;
            moved = 1'b1;
        end
        if (ph == PH_TO_B) begin
            blk = moved ? to_zero : el_ge_to;
            if (arr_b || blk) begin
                steps.shot     = 1'b1;
                steps.shot_blk = blk;
                ph    = (!blk && shots_dec != 8'd0) ? PH_TO_A : PH_RETURN;
                moved = 1'b1;
            end
        end
        if (ph == PH_RETURN && (arr_a || (moved ? to_zero : el_ge_to))) begin
            steps.go_idle = 1'b1;
            ph    = PH_IDLE;
            moved = 1'b1;
        end
        n_phase = ph;
        n_start = moved ? r_s1_now : r_start;
    end

    always_comb begin
        n_target = r_target;
        n_power  = r_power;
        n_fly    = r_fly;
        n_shots  = r_shots;
        if (steps.go_spin) begin
            n_fly   = FLY_RUN;
            n_shots = shots_cur;
        end
        if (steps.go_fire) begin
            n_power  = r_cfg_fire_pow;
            n_target = r_cfg_pos_a;
        end
        if (steps.go_b) begin
            n_target = r_cfg_pos_b;
        end
        if (steps.shot) begin
            n_target = r_cfg_pos_a;
            n_shots  = steps.shot_blk ? 8'd0 : shots_dec;
        end
        if (steps.go_idle) begin
            n_fly   = FLY_STOP;
            n_power = r_cfg_hold_pow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pos_a    <= POSITION_BITS'(POS_A_RST);
            r_cfg_pos_b    <= POSITION_BITS'(POS_B_RST);
            r_cfg_burst    <= BURST_RST;
            r_cfg_spinup   <= SPINUP_RST;
            r_cfg_timeout  <= TIMEOUT_RST;
            r_cfg_tol      <= TOL_RST;
            r_cfg_fire_pow <= FIRE_POW_RST;
            r_cfg_hold_pow <= HOLD_POW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_POS_A:    r_cfg_pos_a    <= i_cfg_data[POSITION_BITS-1:0];
                CFG_POS_B:    r_cfg_pos_b    <= i_cfg_data[POSITION_BITS-1:0];
                CFG_BURST:    r_cfg_burst    <= i_cfg_data[7:0];
                CFG_SPINUP:   r_cfg_spinup   <= i_cfg_data[15:0];
                CFG_TIMEOUT:  r_cfg_timeout  <= i_cfg_data[15:0];
                CFG_TOL:      r_cfg_tol      <= i_cfg_data[9:0];
                CFG_FIRE_POW: r_cfg_fire_pow <= i_cfg_data[6:0];
                CFG_HOLD_POW: r_cfg_hold_pow <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_now  <= i_now_ms;
            r_s1_trig <= i_trigger_level;
            r_s1_pos  <= i_motor_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_start     <= '0;
            r_shots     <= 8'd0;
            r_last_trig <= 1'b1;
            r_target    <= POSITION_BITS'(POS_A_RST);
            r_power     <= HOLD_POW_RST;
            r_fly       <= FLY_STOP;
        end else begin
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (take) begin
                r_phase     <= n_phase;
                r_start     <= n_start;
                r_shots     <= n_shots;
                r_last_trig <= r_s1_trig;
                r_target    <= n_target;
                r_power     <= n_power;
                r_fly       <= n_fly;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_motor_target     = r_target;
    assign o_drive_power      = r_power;
    assign o_flywheel_compare = r_fly;
    assign o_phase            = r_phase;

endmodule

`default_nettype wire

### rtl/bfms_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "burst_fire_motion_sequencer_core_defines.svh"

module bfms_checker #(
    parameter int POSITION_BITS = bfms_pkg::POSITION_BITS_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic signed [POSITION_BITS-1:0] o_motor_target,
    input wire logic [10:0]                     o_flywheel_compare,
    input wire logic [2:0]                      o_phase
);

    import bfms_pkg::*;

    `BFMS_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled while result side free")

    `BFMS_ASSERT_NOW(a_idle_means_stopped, i_clk, i_rst_n, 1'b1, (o_phase == PH_IDLE) == (o_flywheel_compare == FLY_STOP), "flywheel state disagrees with phase")

    `BFMS_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_phase) && $stable(o_motor_target), "stalled result beat changed")

endmodule

bind burst_fire_motion_sequencer_core bfms_checker #(.POSITION_BITS(POSITION_BITS)) u_bfms_checker (.*);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bfms_pkg::*;

    typedef struct packed {
        logic signed [23:0] target;
        logic [6:0]         power;
        logic [10:0]        fly;
        logic [2:0]         phase;
    } t_feed_out;

    typedef struct packed {
        logic               is_reg;
        logic [2:0]         idx;
        logic [23:0]        data;
        logic [31:0]        now;
        logic               trig;
        logic signed [23:0] pos;
        logic               typed;
        t_feed_out          want;
    } t_drill_row;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic [31:0]        i_now_ms         = '0;
    logic               i_trigger_level  = 1'b1;
    logic signed [23:0] i_motor_position = '0;
    logic               i_out_stall      = 1'b0;
    logic               i_cfg_valid      = 1'b0;
    logic [2:0]         i_cfg_index      = '0;
    logic [23:0]        i_cfg_data       = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [23:0] o_motor_target;
    logic [6:0]         o_drive_power;
    logic [10:0]        o_flywheel_compare;
    logic [2:0]         o_phase;
    logic               o_cfg_ready;

    // feed sequencer settings as the block should hold them
    logic signed [23:0] cfg_pos_a   = 24'(POS_A_RST);
    logic signed [23:0] cfg_pos_b   = 24'(POS_B_RST);
    logic [7:0]         cfg_burst   = BURST_RST;
    logic [15:0]        cfg_spinup  = SPINUP_RST;
    logic [15:0]        cfg_timeout = TIMEOUT_RST;
    logic [9:0]         cfg_tol     = TOL_RST;
    logic [6:0]         cfg_fire    = FIRE_POW_RST;
    logic [6:0]         cfg_hold    = HOLD_POW_RST;

    t_phase             ph        = PH_IDLE;
    logic [31:0]        ph_start  = '0;
    logic [7:0]         shots     = '0;
    logic               last_trig = 1'b1;
    logic signed [23:0] tgt       = 24'(POS_A_RST);
    logic [6:0]         pwr       = HOLD_POW_RST;
    logic [10:0]        fly       = FLY_STOP;

    t_feed_out   feed_due[$];
    t_drill_row  drill[$];
    int          bad_beats = 0;
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned gap_plan[4]   = '{0, 79, 0, 30};
    int unsigned stall_plan[4] = '{0, 0, 79, 30};
    logic [31:0] ms_now = '0;

    burst_fire_motion_sequencer_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_now_ms           (i_now_ms),
        .i_trigger_level    (i_trigger_level),
        .i_motor_position   (i_motor_position),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_motor_target     (o_motor_target),
        .o_drive_power      (o_drive_power),
        .o_flywheel_compare (o_flywheel_compare),
        .o_phase            (o_phase),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [31:0] since(logic [31:0] now);
        return now - ph_start;
    endfunction

    function automatic logic near(logic signed [23:0] pos, logic signed [23:0] dest);
        longint d;
        d = longint'(pos) - longint'(dest);
        if (d < 0) d = -d;
        return d < longint'(cfg_tol);
    endfunction

    function automatic t_feed_out advance_feed(logic [31:0] now, logic trig,
                                               logic signed [23:0] pos);
        logic      blocked;
        t_feed_out r;
        if (last_trig && !trig && ph == PH_IDLE) begin
            ph       = PH_SPINUP;
            ph_start = now;
            fly      = FLY_RUN;
            shots    = (cfg_burst == 8'd0) ? 8'd1 : cfg_burst;
        end
        if (ph == PH_SPINUP && since(now) >= 32'(cfg_spinup)) begin
            ph       = PH_TO_A;
            ph_start = now;
            pwr      = cfg_fire;
            tgt      = cfg_pos_a;
        end
        if (ph == PH_TO_A && (near(pos, cfg_pos_a) || since(now) >= 32'(cfg_timeout))) begin
            ph       = PH_TO_B;
            ph_start = now;
            tgt      = cfg_pos_b;
        end
        if (ph == PH_TO_B) begin
            blocked = since(now) >= 32'(cfg_timeout);
            if (near(pos, cfg_pos_b) || blocked) begin
                tgt      = cfg_pos_a;
                shots    = blocked ? 8'd0 : shots - 8'd1;
                ph       = (shots != 8'd0) ? PH_TO_A : PH_RETURN;
                ph_start = now;
            end
        end
        if (ph == PH_RETURN && (near(pos, cfg_pos_a) || since(now) >= 32'(cfg_timeout))) begin
            fly      = FLY_STOP;
            ph       = PH_IDLE;
            ph_start = now;
            pwr      = cfg_hold;
        end
        last_trig = trig;
        r.target  = tgt;
        r.power   = pwr;
        r.fly     = fly;
        r.phase   = ph;
        return r;
    endfunction

    function automatic void poll_row(logic [31:0] now, logic trig, logic signed [23:0] pos);
        t_drill_row r;
        r      = '0;
        r.now  = now;
        r.trig = trig;
        r.pos  = pos;
        drill.push_back(r);
    endfunction

    function automatic void seen_row(logic [31:0] now, logic trig, logic signed [23:0] pos,
                                     logic signed [23:0] tgt_w, logic [6:0] pwr_w,
                                     logic [10:0] fly_w, t_phase ph_w);
        t_drill_row r;
        r              = '0;
        r.now          = now;
        r.trig         = trig;
        r.pos          = pos;
        r.typed        = 1'b1;
        r.want.target  = tgt_w;
        r.want.power   = pwr_w;
        r.want.fly     = fly_w;
        r.want.phase   = ph_w;
        drill.push_back(r);
    endfunction

    function automatic void reg_row(logic [2:0] idx, logic [23:0] data);
        t_drill_row r;
        r        = '0;
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        drill.push_back(r);
    endfunction

    task automatic send_poll(logic [31:0] now, logic trig, logic signed [23:0] pos,
                             logic typed, t_feed_out want);
        t_feed_out calc;
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_now_ms         <= now;
        i_trigger_level  <= trig;
        i_motor_position <= pos;
        // hold the beat until it is taken
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        calc = advance_feed(now, trig, pos);
        feed_due.push_back(typed ? want : calc);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_POS_A:    cfg_pos_a   = data;
            CFG_POS_B:    cfg_pos_b   = data;
            CFG_BURST:    cfg_burst   = data[7:0];
            CFG_SPINUP:   cfg_spinup  = data[15:0];
            CFG_TIMEOUT:  cfg_timeout = data[15:0];
            CFG_TOL:      cfg_tol     = data[9:0];
            CFG_FIRE_POW: cfg_fire    = data[6:0];
            CFG_HOLD_POW: cfg_hold    = data[6:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle_feed();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (feed_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_spot();
        if ($urandom_range(1) != 0) return 24'($urandom_range(4000)) - 24'd2000;
        return 24'($urandom);
    endfunction

    function automatic logic [15:0] pick_ms();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return 16'd0;
        if (r < 75) return 16'($urandom_range(60));
        return 16'($urandom_range(65535));
    endfunction

    task automatic shuffle_settings();
        logic [23:0] junk;
        logic [9:0]  tol;
        int unsigned r;
        junk = 24'($urandom);
        r    = $urandom_range(99);
        tol  = (r < 20) ? (($urandom_range(1) != 0) ? 10'd1 : 10'd1023)
             : (r < 70) ? 10'($urandom_range(40, 1)) : 10'($urandom_range(1023));
        if ($urandom_range(99) < 70) write_reg(CFG_POS_A, pick_spot());
        if ($urandom_range(99) < 70) write_reg(CFG_POS_B, pick_spot());
        if ($urandom_range(99) < 70)
            write_reg(CFG_BURST, {junk[23:8], ($urandom_range(99) < 70) ?
                                  8'($urandom_range(4)) : 8'($urandom)});
        if ($urandom_range(99) < 70) write_reg(CFG_SPINUP, {junk[23:16], pick_ms()});
        if ($urandom_range(99) < 70) write_reg(CFG_TIMEOUT, {junk[23:16], pick_ms()});
        if ($urandom_range(99) < 70) write_reg(CFG_TOL, {junk[23:10], tol});
        if ($urandom_range(99) < 70)
            write_reg(CFG_FIRE_POW, {junk[23:7], 7'($urandom_range(127))});
        if ($urandom_range(99) < 70)
            write_reg(CFG_HOLD_POW, {junk[23:7], 7'($urandom_range(127))});
    endtask

    task automatic fire_polls(int unsigned count);
        logic signed [23:0] aim;
        logic signed [23:0] pos;
        logic [31:0]        bar;
        logic               trig;
        int                 tol_i;
        int                 off;
        int unsigned        pick;
        repeat (count) begin
            // land on either side of the running deadline now and then
            pick = $urandom_range(99);
            bar  = (ph == PH_SPINUP) ? 32'(cfg_spinup) : 32'(cfg_timeout);
            if (pick < 3)
                ms_now = $urandom;
            else if (pick < 20)
                ms_now = ph_start + bar - 32'd1 + 32'($urandom_range(2));
            else
                ms_now = ms_now + 32'($urandom_range(40));
            trig  = ($urandom_range(99) < ((ph == PH_IDLE) ? 50 : 15)) ? 1'b0 : 1'b1;
            aim   = (ph == PH_TO_B) ? cfg_pos_b : cfg_pos_a;
            tol_i = int'(cfg_tol);
            pick  = $urandom_range(99);
            if (pick < 35) begin
                off = int'($urandom_range(2 * tol_i + 2)) - tol_i - 1;
                pos = aim + 24'(off);
            end else if (pick < 45) begin
                off = tol_i - int'($urandom_range(1));
                if ($urandom_range(1) != 0) off = -off;
                pos = aim + 24'(off);
            end else begin
                pos = 24'($urandom);
            end
            send_poll(ms_now, trig, pos, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_feed_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (feed_due.size() == 0) begin
                if (bad_beats < 10)
                    $display("unexpected beat: target %0d power %0d fly %0d phase %0d",
                             o_motor_target, o_drive_power, o_flywheel_compare, o_phase);
                bad_beats++;
            end else begin
                want = feed_due.pop_front();
                if (o_motor_target !== want.target || o_drive_power !== want.power ||
                    o_flywheel_compare !== want.fly || o_phase !== want.phase) begin
                    if (bad_beats < 10)
                        $display({"mismatch exp/got: target %0d/%0d power %0d/%0d",
                                  " fly %0d/%0d phase %0d/%0d"},
                                 want.target, o_motor_target, want.power, o_drive_power,
                                 want.fly, o_flywheel_compare, want.phase, o_phase);
                    bad_beats++;
                end
            end
        end
    end

    initial begin
        seen_row(32'd0,        1'b1, 24'sd0,    24'sd0,    7'd32,  FLY_STOP, PH_IDLE);
        seen_row(32'd100,      1'b0, 24'sd0,    24'sd0,    7'd32,  FLY_RUN,  PH_SPINUP);
        seen_row(32'd200,      1'b0, 24'sd0,    24'sd0,    7'd32,  FLY_RUN,  PH_SPINUP);
        seen_row(32'd700,      1'b1, 24'sd5,    -24'sd600, 7'd127, FLY_RUN,  PH_TO_B);
        seen_row(32'd710,      1'b1, -24'sd595, 24'sd0,    7'd127, FLY_RUN,  PH_TO_A);
        seen_row(32'd720,      1'b0, -24'sd9,   -24'sd600, 7'd127, FLY_RUN,  PH_TO_B);
        seen_row(32'd1020,     1'b1, 24'sd0,    24'sd0,    7'd32,  FLY_STOP, PH_IDLE);
        seen_row(32'hFFFFFF00, 1'b0, 24'sd0,    24'sd0,    7'd32,  FLY_RUN,  PH_SPINUP);
        seen_row(32'h00000200, 1'b0, 24'sd0,    -24'sd600, 7'd127, FLY_RUN,  PH_TO_B);
        seen_row(32'd812,      1'b1, -24'sd600, 24'sd0,    7'd127, FLY_RUN,  PH_RETURN);
        seen_row(32'd1112,     1'b1, -24'sd600, 24'sd0,    7'd32,  FLY_STOP, PH_IDLE);
        reg_row(CFG_BURST,    24'd0);
        reg_row(CFG_SPINUP,   24'd0);
        reg_row(CFG_TIMEOUT,  24'd0);
        reg_row(CFG_POS_A,    24'h800000);
        reg_row(CFG_POS_B,    24'h7FFFFF);
        reg_row(CFG_TOL,      24'd1023);
        reg_row(CFG_FIRE_POW, 24'd0);
        reg_row(CFG_HOLD_POW, 24'd127);
        seen_row(32'd5, 1'b1, 24'sd0,      24'sd0,      7'd32,  FLY_STOP, PH_IDLE);
        seen_row(32'd6, 1'b0, 24'sh800000, 24'sh800000, 7'd127, FLY_STOP, PH_IDLE);
        seen_row(32'd7, 1'b0, 24'sh7FFFFF, 24'sh800000, 7'd127, FLY_STOP, PH_IDLE);
        seen_row(32'd8, 1'b1, 24'sd0,      24'sh800000, 7'd127, FLY_STOP, PH_IDLE);
        reg_row(CFG_POS_A,    24'h7FFFFF);
        reg_row(CFG_POS_B,    24'h800000);
        reg_row(CFG_BURST,    24'd255);
        reg_row(CFG_SPINUP,   24'd65535);
        reg_row(CFG_TIMEOUT,  24'd65535);
        reg_row(CFG_TOL,      24'd1);
        reg_row(CFG_FIRE_POW, 24'd127);
        reg_row(CFG_HOLD_POW, 24'd0);
        seen_row(32'hFFFFFFFF, 1'b0, 24'sh7FFFFF, 24'sh800000, 7'd127, FLY_RUN, PH_SPINUP);
        seen_row(32'h0000FFFE, 1'b1, 24'sh7FFFFF, 24'sh800000, 7'd127, FLY_RUN, PH_TO_B);
        seen_row(32'h0000FFFF, 1'b1, 24'sh800000, 24'sh7FFFFF, 7'd127, FLY_RUN, PH_TO_A);
        seen_row(32'h00010000, 1'b1, 24'sh7FFFFE, 24'sh7FFFFF, 7'd127, FLY_RUN, PH_TO_A);
        poll_row(32'h0001FFFF, 1'b1, 24'sd0);
        poll_row(32'hAAAA5555, 1'b0, 24'sh555AAA);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (drill[k]) begin
            if (drill[k].is_reg) begin
                settle_feed();
                write_reg(drill[k].idx, drill[k].data);
            end else begin
                send_poll(drill[k].now, drill[k].trig, drill[k].pos,
                          drill[k].typed, drill[k].want);
            end
        end

        for (int p = 0; p < 4; p++) begin
            gap_pct   = gap_plan[p];
            stall_pct = stall_plan[p];
            repeat (6) begin
                settle_feed();
                shuffle_settings();
                fire_polls(47);
            end
        end

        settle_feed();
        repeat (6) @(posedge i_clk);
        if (bad_beats == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        #400_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
